>>> design/bbc96_pkg.sv
// ----------------------------------------------------------------------------
// bbc96_pkg: shared definitions for the 96-bit binary/BCD converter
// Widths, default sizes, micro-operation and jump codes, and the control
// store that sequences the conversion datapath.
// ----------------------------------------------------------------------------
package bbc96_pkg;

    // Default sizes and fixed port widths.
    localparam int DigitsDefault   = 30;
    localparam int BinWidthDefault = 96;
    localparam int BinPortW        = 96;
    localparam int DigitPortN      = 30;
    localparam int BinLowW         = 64;
    localparam int BinHighW        = 32;
    localparam int DecLowW         = 64;
    localparam int DecHighW        = 56;
    localparam int DecPortW        = DecLowW + DecHighW;

    // Step counter of the sequencer.
    localparam int StepW = 3;
    typedef logic [StepW-1:0] t_step;

    // Micro-operations applied to the datapath.
    typedef enum logic [2:0] {
        OP_NOP  = 3'd0,
        OP_LOAD = 3'd1,
        OP_DBL  = 3'd2,
        OP_MAC  = 3'd3,
        OP_EMIT = 3'd4
    } t_op;

    // Jump conditions; the jump is taken when the condition holds.
    typedef enum logic [2:0] {
        JC_NEVER  = 3'd0,
        JC_ALWAYS = 3'd1,
        JC_NOIN   = 3'd2,
        JC_CMD    = 3'd3,
        JC_CNT_NZ = 3'd4,
        JC_OBUSY  = 3'd5
    } t_jc;

    // One control word of the program.
    typedef struct packed {
        t_op   op;
        t_jc   jc;
        t_step target;
    } t_ctrl_word;

    // Program addresses.
    localparam t_step StIdle  = 3'd0;
    localparam t_step StSplit = 3'd1;
    localparam t_step StDbl   = 3'd2;
    localparam t_step StJoin  = 3'd3;
    localparam t_step StMac   = 3'd4;
    localparam t_step StEmit  = 3'd5;
    localparam t_step StBack  = 3'd6;

    // Control store: wait for a word, branch on direction, iterate the
    // doubling or the multiply-by-ten step, then hand over the result.
    function automatic t_ctrl_word f_ucode(input t_step step);
        t_ctrl_word w;
        case (step)
            StIdle:  w = '{op: OP_LOAD, jc: JC_NOIN,   target: StIdle};
            StSplit: w = '{op: OP_NOP,  jc: JC_CMD,    target: StMac};
            StDbl:   w = '{op: OP_DBL,  jc: JC_CNT_NZ, target: StDbl};
            StJoin:  w = '{op: OP_NOP,  jc: JC_ALWAYS, target: StEmit};
            StMac:   w = '{op: OP_MAC,  jc: JC_CNT_NZ, target: StMac};
            StEmit:  w = '{op: OP_EMIT, jc: JC_OBUSY,  target: StEmit};
            StBack:  w = '{op: OP_NOP,  jc: JC_ALWAYS, target: StIdle};
            default: w = '{op: OP_NOP,  jc: JC_ALWAYS, target: StIdle};
        endcase
        return w;
    endfunction

endpackage

>>> design/binary_bcd_converter_96_core.sv
// ----------------------------------------------------------------------------
// binary_bcd_converter_96_core: microcoded binary <-> BCD converter
// Converts a 96-bit unsigned binary value to 30 BCD digits (cmd 0) or
// 30 BCD digits to binary (cmd 1), one bit or one digit per cycle.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+------------------------------
//   input   | in        | i_valid / o_ready  | cmd, bin_low/high, dec_low/high
//   output  | out       | o_valid / i_ready  | bin/dec low/high, overflow,
//           |           |                    | bad_digit
//
// Binary to BCD performs one decimal doubling per binary bit; BCD to binary
// performs one multiply-by-ten add per digit. After the loop, the result is
// registered into the output register at the hand-over step.
// Reset clears the step counter and the output valid; the block is ready
// in the first cycle after reset.
// A stalled output holds the sequencer at its hand-over step; a new word is
// taken once the finished one has moved into the output register.
// ----------------------------------------------------------------------------
module binary_bcd_converter_96_core #(
    parameter int DIGITS    = bbc96_pkg::DigitsDefault,
    parameter int BIN_WIDTH = bbc96_pkg::BinWidthDefault
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_cmd,
    input  logic [bbc96_pkg::BinLowW-1:0]  i_bin_low,
    input  logic [bbc96_pkg::BinHighW-1:0] i_bin_high,
    input  logic [bbc96_pkg::DecLowW-1:0]  i_dec_low,
    input  logic [bbc96_pkg::DecHighW-1:0] i_dec_high,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [bbc96_pkg::BinLowW-1:0]  o_bin_low_out,
    output logic [bbc96_pkg::BinHighW-1:0] o_bin_high_out,
    output logic [bbc96_pkg::DecLowW-1:0]  o_dec_low_out,
    output logic [bbc96_pkg::DecHighW-1:0] o_dec_high_out,
    output logic                          o_overflow,
    output logic                          o_bad_digit
);
    import bbc96_pkg::*;

    // Widths actually carried by the ports.
    localparam int KW    = (BIN_WIDTH < BinPortW) ? BIN_WIDTH : BinPortW;
    localparam int KD    = (DIGITS < DigitPortN) ? DIGITS : DigitPortN;
    localparam int DW    = 4 * KD;
    localparam int MAXN  = (KW > KD) ? KW : KD;
    localparam int CNT_W = $clog2(MAXN);

    // Sequencer and datapath registers.
    t_step            r_step, n_step;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_cmd, n_cmd;
    logic [KW-1:0]    r_bin, n_bin;
    logic [DW-1:0]    r_dec, n_dec;
    logic             r_ovf, n_ovf;
    logic             r_bad, n_bad;

    // Output register.
    logic                r_ovalid, n_ovalid;
    logic [BinPortW-1:0] r_obin, n_obin;
    logic [DecPortW-1:0] r_odec, n_odec;
    logic                r_oovf, n_oovf;
    logic                r_obad, n_obad;

    // Current control word and helpers.
    t_ctrl_word        w_cw;
    logic              w_cond;
    logic              w_obusy;
    logic [BinPortW-1:0] w_bin_in;
    logic [DecPortW-1:0] w_dec_in;
    logic [DW-1:0]     w_dbl;
    logic [KD:0]       w_dcarry;
    logic [KW+3:0]     w_mac;
    logic [3:0]        w_digit;

    assign w_cw     = f_ucode(r_step);
    assign o_ready  = (r_step == StIdle);
    assign w_obusy  = r_ovalid && !i_ready;
    assign w_bin_in = {i_bin_high, i_bin_low};
    assign w_dec_in = {i_dec_high, i_dec_low};

    // Decimal doubling: a digit carries out exactly when it is five or more.
    always_comb begin
        w_dcarry[0] = r_bin[KW-1];
        for (int k = 0; k < KD; k++) begin
            w_dcarry[k+1] = (r_dec[4*k +: 4] >= 4'd5);
            if (w_dcarry[k+1]) begin
                w_dbl[4*k +: 4] = {r_dec[4*k +: 3], w_dcarry[k]} - 4'd10;
            end else begin
                w_dbl[4*k +: 4] = {r_dec[4*k +: 3], w_dcarry[k]};
            end
        end
    end

    // Multiply by ten and add the top remaining digit.
    assign w_digit = r_dec[DW-1 -: 4];
    assign w_mac   = ({4'd0, r_bin} << 3) + ({4'd0, r_bin} << 1) + (KW+4)'(w_digit);

    // Jump condition select.
    always_comb begin
        case (w_cw.jc)
            JC_NEVER:  w_cond = 1'b0;
            JC_ALWAYS: w_cond = 1'b1;
            JC_NOIN:   w_cond = !i_valid;
            JC_CMD:    w_cond = r_cmd;
            JC_CNT_NZ: w_cond = (r_cnt != '0);
            JC_OBUSY:  w_cond = w_obusy;
            default:   w_cond = 1'b0;
        endcase
    end

    // Next step and datapath operation.
    always_comb begin
        n_step   = w_cond ? w_cw.target : r_step + t_step'(1);
        n_cnt    = r_cnt;
        n_cmd    = r_cmd;
        n_bin    = r_bin;
        n_dec    = r_dec;
        n_ovf    = r_ovf;
        n_bad    = r_bad;
        n_ovalid = r_ovalid && !i_ready;
        n_obin   = r_obin;
        n_odec   = r_odec;
        n_oovf   = r_oovf;
        n_obad   = r_obad;
        case (w_cw.op)
            OP_LOAD: begin
                if (i_valid) begin
                    n_cmd = i_cmd;
                    n_ovf = 1'b0;
                    n_bad = 1'b0;
                    if (i_cmd) begin
                        n_cnt = CNT_W'(KD - 1);
                        n_bin = '0;
                        n_dec = w_dec_in[DW-1:0];
                    end else begin
                        n_cnt = CNT_W'(KW - 1);
                        n_bin = w_bin_in[KW-1:0];
                        n_dec = '0;
                    end
                end
            end
            OP_DBL: begin
                n_cnt = r_cnt - CNT_W'(1);
                n_bin = r_bin << 1;
                n_dec = w_dbl;
                n_ovf = r_ovf | w_dcarry[KD];
            end
            OP_MAC: begin
                n_cnt = r_cnt - CNT_W'(1);
                n_bin = w_mac[KW-1:0];
                n_dec = r_dec << 4;
                n_ovf = r_ovf | (w_mac[KW+3:KW] != 4'd0);
                n_bad = r_bad | (w_digit > 4'd9);
            end
            OP_EMIT: begin
                if (!w_obusy) begin
                    n_ovalid = 1'b1;
                    n_obin   = (r_cmd && !r_bad) ? BinPortW'(r_bin) : '0;
                    n_odec   = r_cmd ? '0 : DecPortW'(r_dec);
                    n_oovf   = r_ovf && !r_bad;
                    n_obad   = r_bad;
                end
            end
            default: begin
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step   <= StIdle;
            r_ovalid <= 1'b0;
        end else begin
            r_step   <= n_step;
            r_ovalid <= n_ovalid;
        end
    end

    // Datapath and output payload.
    always_ff @(posedge i_clk) begin
        r_cnt  <= n_cnt;
        r_cmd  <= n_cmd;
        r_bin  <= n_bin;
        r_dec  <= n_dec;
        r_ovf  <= n_ovf;
        r_bad  <= n_bad;
        r_obin <= n_obin;
        r_odec <= n_odec;
        r_oovf <= n_oovf;
        r_obad <= n_obad;
    end

    // Output ports.
    assign o_valid        = r_ovalid;
    assign o_bin_low_out  = r_obin[BinLowW-1:0];
    assign o_bin_high_out = r_obin[BinPortW-1:BinLowW];
    assign o_dec_low_out  = r_odec[DecLowW-1:0];
    assign o_dec_high_out = r_odec[DecPortW-1:DecLowW];
    assign o_overflow     = r_oovf;
    assign o_bad_digit    = r_obad;

endmodule

>>> sim/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for binary_bcd_converter_96_core
// Sends words in both directions, binary to BCD and BCD to binary. A
// behavioral converter predicts every result, and each result is checked
// field by field in arrival order. Sender gaps and receiver stalls change
// across phases of the run.
// ----------------------------------------------------------------------------
module tb;
    import bbc96_pkg::*;

    localparam int ClkHalf     = 4;
    localparam int ResetCycles = 11;
    localparam int RandomWords = 1330;
    localparam int CycleLimit  = 1_000_000;
    // Wait after the last expected result, before the final check.
    localparam int DrainCycles = 150;
    localparam int ReportMax   = 10;

    localparam logic CmdToBcd = 1'b0;
    localparam logic CmdToBin = 1'b1;

    // One input word as it is presented to the converter.
    typedef struct packed {
        logic                cmd;
        logic [BinLowW-1:0]  bin_low;
        logic [BinHighW-1:0] bin_high;
        logic [DecLowW-1:0]  dec_low;
        logic [DecHighW-1:0] dec_high;
    } t_conv_word;

    // One converted result.
    typedef struct packed {
        logic [BinLowW-1:0]  bin_low;
        logic [BinHighW-1:0] bin_high;
        logic [DecLowW-1:0]  dec_low;
        logic [DecHighW-1:0] dec_high;
        logic                overflow;
        logic                bad_digit;
    } t_conv_result;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    logic                in_valid    = 1'b0;
    logic                in_ready;
    logic                in_cmd      = 1'b0;
    logic [BinLowW-1:0]  in_bin_low  = '0;
    logic [BinHighW-1:0] in_bin_high = '0;
    logic [DecLowW-1:0]  in_dec_low  = '0;
    logic [DecHighW-1:0] in_dec_high = '0;

    logic                out_valid;
    logic                out_ready = 1'b0;
    logic [BinLowW-1:0]  out_bin_low;
    logic [BinHighW-1:0] out_bin_high;
    logic [DecLowW-1:0]  out_dec_low;
    logic [DecHighW-1:0] out_dec_high;
    logic                out_overflow;
    logic                out_bad_digit;

    t_conv_word   word_q[$];
    t_conv_result expected_q[$];

    int total_words  = 0;
    int accepted_cnt = 0;
    int cycle_cnt    = 0;
    int error_cnt    = 0;
    int to_bcd_cnt   = 0;
    int to_bin_cnt   = 0;
    int overflow_cnt = 0;
    int bad_cnt      = 0;
    int phase;
    int idle_pct;
    int stall_pct;

    binary_bcd_converter_96_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (in_valid),
        .o_ready       (in_ready),
        .i_cmd         (in_cmd),
        .i_bin_low     (in_bin_low),
        .i_bin_high    (in_bin_high),
        .i_dec_low     (in_dec_low),
        .i_dec_high    (in_dec_high),
        .o_valid       (out_valid),
        .i_ready       (out_ready),
        .o_bin_low_out (out_bin_low),
        .o_bin_high_out(out_bin_high),
        .o_dec_low_out (out_dec_low),
        .o_dec_high_out(out_dec_high),
        .o_overflow    (out_overflow),
        .o_bad_digit   (out_bad_digit)
    );

    // Packs a value into BCD digits by repeated division; spill tells that
    // the value needs more digits than the port holds.
    function automatic logic [DecPortW-1:0] to_bcd(input logic [127:0] value,
                                                   output logic spill);
        logic [DecPortW-1:0] digits;
        logic [127:0]        rest;
        digits = '0;
        rest   = value;
        for (int k = 0; k < DigitPortN; k++) begin
            digits[4*k +: 4] = 4'(rest % 128'd10);
            rest             = rest / 128'd10;
        end
        spill = (rest != 0);
        return digits;
    endfunction

    // Predicts the result of one word.
    function automatic t_conv_result convert_word(input t_conv_word w);
        t_conv_result        r;
        logic [DecPortW-1:0] digits;
        logic [127:0]        acc;
        logic [3:0]          d;
        logic                spill;
        r = '0;
        if (w.cmd == CmdToBcd) begin
            digits     = to_bcd({32'd0, w.bin_high, w.bin_low}, spill);
            r.dec_low  = digits[DecLowW-1:0];
            r.dec_high = digits[DecPortW-1:DecLowW];
            r.overflow = spill;
        end else begin
            digits = {w.dec_high, w.dec_low};
            acc    = '0;
            // Accumulate from the top digit down; 30 digits fit in 128 bits.
            for (int i = DigitPortN - 1; i >= 0; i--) begin
                d = digits[4*i +: 4];
                if (d > 4'd9) begin
                    r.bad_digit = 1'b1;
                end
                acc = acc * 128'd10 + 128'(d);
            end
            if (!r.bad_digit) begin
                r.bin_low  = acc[BinLowW-1:0];
                r.bin_high = acc[BinPortW-1:BinLowW];
                r.overflow = (acc[127:BinPortW] != 0);
            end
        end
        return r;
    endfunction

    // Appends one word to the pending queue.
    task automatic queue_word(input logic cmd, input logic [BinPortW-1:0] bin,
                              input logic [DecPortW-1:0] dec);
        t_conv_word w;
        w.cmd      = cmd;
        w.bin_low  = bin[BinLowW-1:0];
        w.bin_high = bin[BinPortW-1:BinLowW];
        w.dec_low  = dec[DecLowW-1:0];
        w.dec_high = dec[DecPortW-1:DecLowW];
        word_q.push_back(w);
    endtask

    // Random BCD string of random length, every digit valid.
    function automatic logic [DecPortW-1:0] rand_bcd();
        logic [DecPortW-1:0] dec;
        int                  ndig;
        dec  = '0;
        ndig = $urandom_range(DigitPortN, 1);
        for (int i = 0; i < ndig; i++) begin
            dec[4*i +: 4] = 4'($urandom_range(9, 0));
        end
        return dec;
    endfunction

    // Clock.
    initial begin
        forever begin
            #ClkHalf i_clk = ~i_clk;
        end
    end

    // Reset is held at the start of the run only.
    initial begin
        repeat (ResetCycles) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // Gap and stall rates follow the share of words accepted so far.
    assign phase = (total_words == 0) ? 0 : (accepted_cnt * 5) / total_words;

    always_comb begin
        case (phase)
            1: begin
                idle_pct  = 58;
                stall_pct = 0;
            end
            2: begin
                idle_pct  = 0;
                stall_pct = 58;
            end
            3: begin
                idle_pct  = 13;
                stall_pct = 13;
            end
            default: begin
                idle_pct  = 0;
                stall_pct = 0;
            end
        endcase
    end

    // Cycle counter for the run limit.
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
    end

    // Driver: presents queued words and predicts each accepted one.
    always @(posedge i_clk) begin : driver
        t_conv_word w;
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && in_ready) begin
                w.cmd      = in_cmd;
                w.bin_low  = in_bin_low;
                w.bin_high = in_bin_high;
                w.dec_low  = in_dec_low;
                w.dec_high = in_dec_high;
                expected_q.push_back(convert_word(w));
                if (in_cmd == CmdToBcd) begin
                    to_bcd_cnt++;
                end else begin
                    to_bin_cnt++;
                end
                accepted_cnt <= accepted_cnt + 1;
            end
            if (!in_valid || in_ready) begin
                if (word_q.size() > 0 && $urandom_range(99, 0) >= idle_pct) begin
                    w = word_q.pop_front();
                    in_cmd      <= w.cmd;
                    in_bin_low  <= w.bin_low;
                    in_bin_high <= w.bin_high;
                    in_dec_low  <= w.dec_low;
                    in_dec_high <= w.dec_high;
                    in_valid    <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each result word against the oldest prediction.
    always @(posedge i_clk) begin : monitor
        t_conv_result got;
        t_conv_result want;
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_valid && out_ready) begin
                got.bin_low   = out_bin_low;
                got.bin_high  = out_bin_high;
                got.dec_low   = out_dec_low;
                got.dec_high  = out_dec_high;
                got.overflow  = out_overflow;
                got.bad_digit = out_bad_digit;
                if (expected_q.size() == 0) begin
                    error_cnt++;
                    if (error_cnt <= ReportMax) begin
                        $display("ERROR: result word with none expected: %p", got);
                    end
                end else begin
                    want = expected_q.pop_front();
                    overflow_cnt += want.overflow;
                    bad_cnt      += want.bad_digit;
                    if (got.bin_low != want.bin_low || got.bin_high != want.bin_high ||
                        got.dec_low != want.dec_low || got.dec_high != want.dec_high ||
                        got.overflow != want.overflow ||
                        got.bad_digit != want.bad_digit) begin
                        error_cnt++;
                        if (error_cnt <= ReportMax) begin
                            $display("ERROR: mismatch at cycle %0d", cycle_cnt);
                            $display("  expected bin=%h_%h dec=%h_%h ovf=%b bad=%b",
                                     want.bin_high, want.bin_low, want.dec_high,
                                     want.dec_low, want.overflow, want.bad_digit);
                            $display("  actual   bin=%h_%h dec=%h_%h ovf=%b bad=%b",
                                     got.bin_high, got.bin_low, got.dec_high,
                                     got.dec_low, got.overflow, got.bad_digit);
                        end
                    end
                end
            end
            out_ready <= ($urandom_range(99, 0) >= stall_pct);
        end
    end

    // Run limit.
    initial begin
        wait (cycle_cnt >= CycleLimit);
        $display("Timeout after %0d cycles", cycle_cnt);
        $display("TEST FAILED");
        $finish;
    end

    // Stimulus and end of run.
    initial begin : stimulus
        logic [127:0]        two96;
        logic [DecPortW-1:0] dec;
        logic [BinPortW-1:0] bin;
        logic                spill;
        logic                cmd;
        int                  sel;

        two96 = 128'd1 << BinPortW;

        // Directed: binary to BCD at the extremes.
        queue_word(CmdToBcd, '0, '0);
        queue_word(CmdToBcd, 96'd1, '0);
        queue_word(CmdToBcd, '1, '0);
        queue_word(CmdToBcd, {32'd0, 64'hFFFF_FFFF_FFFF_FFFF}, '0);
        queue_word(CmdToBcd, {32'hFFFF_FFFF, 64'd0}, '0);
        queue_word(CmdToBcd, {24{4'hA}}, '0);
        queue_word(CmdToBcd, {24{4'h5}}, '0);
        queue_word(CmdToBcd, 96'd999_999_999, '0);
        // Decimal fields are ignored in this direction.
        queue_word(CmdToBcd, 96'd12345, '1);

        // Directed: BCD to binary.
        queue_word(CmdToBin, '0, '0);
        queue_word(CmdToBin, '0, {{29{4'h0}}, 4'h1});
        queue_word(CmdToBin, '0, {30{4'h9}});
        queue_word(CmdToBin, '0, to_bcd(two96 - 128'd1, spill));
        queue_word(CmdToBin, '0, to_bcd(two96, spill));
        queue_word(CmdToBin, '0, to_bcd(two96 + 128'd1, spill));
        queue_word(CmdToBin, '0, {4'h9, {29{4'h0}}});
        queue_word(CmdToBin, '0, {30{4'h5}});
        queue_word(CmdToBin, '0, {15{8'h98}});
        // Binary fields are ignored in this direction.
        queue_word(CmdToBin, '1, {{28{4'h0}}, 8'h42});
        // Digits above nine, alone and together with a value too wide.
        queue_word(CmdToBin, '0, {{29{4'h0}}, 4'hA});
        queue_word(CmdToBin, '0, {4'hF, {29{4'h0}}});
        queue_word(CmdToBin, '0, {30{4'hF}});
        queue_word(CmdToBin, '0, {{15{4'h9}}, 4'hC, {14{4'h9}}});

        // Random words in both directions, the unused fields filled with noise.
        for (int n = 0; n < RandomWords; n++) begin
            cmd = 1'($urandom_range(1, 0));
            bin = {$urandom, $urandom, $urandom};
            dec = DecPortW'({$urandom, $urandom, $urandom, $urandom});
            sel = $urandom_range(99, 0);
            if (cmd == CmdToBcd) begin
                if (sel >= 85) begin
                    bin = '1;
                    bin = bin - BinPortW'($urandom_range(1000, 0));
                end else if (sel >= 45) begin
                    bin = bin >> $urandom_range(BinPortW - 1, 0);
                end
            end else begin
                if (sel < 55) begin
                    dec = rand_bcd();
                end else if (sel < 70) begin
                    // Values right around the top of the binary range.
                    if ($urandom_range(1, 0) == 1) begin
                        dec = to_bcd(two96 + 128'($urandom_range(1000, 0)), spill);
                    end else begin
                        dec = to_bcd(two96 - 128'd1 - 128'($urandom_range(1000, 0)),
                                     spill);
                    end
                end else if (sel < 90) begin
                    dec = rand_bcd();
                    for (int b = $urandom_range(3, 1); b > 0; b--) begin
                        dec[4*$urandom_range(DigitPortN - 1, 0) +: 4] =
                            4'($urandom_range(15, 10));
                    end
                end
            end
            queue_word(cmd, bin, dec);
        end
        total_words = word_q.size();

        wait (accepted_cnt == total_words && expected_q.size() == 0);
        repeat (DrainCycles) @(posedge i_clk);
        if (expected_q.size() != 0) begin
            error_cnt++;
            $display("ERROR: %0d result words never arrived", expected_q.size());
        end
        $display("Converted %0d words to BCD and %0d to binary in %0d cycles,",
                 to_bcd_cnt, to_bin_cnt, cycle_cnt);
        $display("with %0d overflows, %0d bad digits and %0d errors.",
                 overflow_cnt, bad_cnt, error_cnt);
        if (error_cnt == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
